// ===== rtl/bss_pkg.sv =====
package bss_pkg;

  localparam int unsigned REQ_TYPE_W = 3;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned POS_W      = 9;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned CNT_W      = 9;

  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_PUSH   = 3'd0,
    REQ_POP    = 3'd1,
    REQ_TOP    = 3'd2,
    REQ_FIND   = 3'd3,
    REQ_SEARCH = 3'd4
  } req_type_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_BAD_POS   = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic    start;      // latch request, launch first read
    logic    push_en;
    logic    pop_en;
    logic    scan_step;  // advance search index, read next entry
    logic    res_load;
    status_e res_status;
    logic    res_data_en;
    logic    res_fpos_en;
  } bss_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [REQ_TYPE_W-1:0] req_type;
    logic                  cnt_zero;
    logic                  can_push;
    logic                  pos_ok;
    logic                  match;
    logic                  scan_last;
  } bss_sts_t;

endpackage

// ===== rtl/bss_req_if.sv =====
interface bss_req_if;
  import bss_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [REQ_TYPE_W-1:0] req_type;
  logic [VALUE_W-1:0]    value;
  logic [POS_W-1:0]      position;

  modport source (output valid, req_type, value, position, input ready);
  modport sink   (input valid, req_type, value, position, output ready);
endinterface

// ===== rtl/bss_rsp_if.sv =====
interface bss_rsp_if;
  import bss_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  data;
  logic [POS_W-1:0]    found_position;
  logic                empty_res;
  logic                full_res;
  logic [CNT_W-1:0]    count;

  modport source (output valid, status, data, found_position, empty_res, full_res, count,
                  input ready);
  modport sink   (input valid, status, data, found_position, empty_res, full_res, count,
                  output ready);
endinterface

// ===== rtl/bss_cfg_if.sv =====
interface bss_cfg_if;
  import bss_pkg::*;

  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/bss_ctrl.sv =====
module bss_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  bss_pkg::bss_sts_t sts_i,
  output bss_pkg::bss_cmd_t cmd_o
);
  import bss_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept;

  // a new request only when the result slot is free or drains this cycle
  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o       = '0;
    cmd_o.res_status = ST_OK;
    cmd_o.start = accept;
    state_d     = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.res_load = 1'b1;
        state_d        = S_IDLE;
        case (sts_i.req_type)
          REQ_PUSH: begin
            if (sts_i.can_push) begin
              cmd_o.push_en = 1'b1;
            end else begin
              cmd_o.res_status = ST_OVERFLOW;
            end
          end
          REQ_POP: begin
            if (sts_i.cnt_zero) begin
              cmd_o.res_status = ST_UNDERFLOW;
            end else begin
              cmd_o.pop_en      = 1'b1;
              cmd_o.res_data_en = 1'b1;
            end
          end
          REQ_TOP: begin
            if (sts_i.cnt_zero) begin
              cmd_o.res_status = ST_UNDERFLOW;
            end else begin
              cmd_o.res_data_en = 1'b1;
            end
          end
          REQ_FIND: begin
            if (sts_i.pos_ok) begin
              cmd_o.res_data_en = 1'b1;
            end else begin
              cmd_o.res_status = ST_BAD_POS;
            end
          end
          REQ_SEARCH: begin
            if (sts_i.cnt_zero) begin
              cmd_o.res_status = ST_NOT_FOUND;
            end else if (sts_i.match) begin
              cmd_o.res_fpos_en = 1'b1;
            end else if (sts_i.scan_last) begin
              cmd_o.res_status = ST_NOT_FOUND;
            end else begin
              cmd_o.res_load  = 1'b0;
              cmd_o.scan_step = 1'b1;
              state_d         = S_EXEC;
            end
          end
          default: begin
            cmd_o.res_status = ST_OK;
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.res_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_EXEC)
    else $error("accepted request did not enter execution");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load |-> !out_valid_q)
    else $error("result loaded over a pending result");

  a_load_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load |=> state_q == S_IDLE && out_valid_q)
    else $error("result load did not present output");
`endif

endmodule

// ===== rtl/bss_datapath.sv =====
module bss_datapath #(
  parameter int unsigned DEPTH      = 256,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bss_pkg::bss_cmd_t            cmd_i,
  output bss_pkg::bss_sts_t            sts_o,
  input  logic [bss_pkg::REQ_TYPE_W-1:0] req_type_i,
  input  logic [bss_pkg::VALUE_W-1:0]  req_value_i,
  input  logic [bss_pkg::POS_W-1:0]    req_pos_i,
  input  logic                         cfg_we_i,
  input  logic [bss_pkg::CNT_W-1:0]    cfg_data_i,
  output logic [bss_pkg::STATUS_W-1:0] status_o,
  output logic [bss_pkg::VALUE_W-1:0]  data_o,
  output logic [bss_pkg::POS_W-1:0]    found_position_o,
  output logic                         empty_o,
  output logic                         full_o,
  output logic [bss_pkg::CNT_W-1:0]    count_o
);
  import bss_pkg::*;

  localparam int unsigned ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CAP_RST = (DEPTH < 256) ? DEPTH : 256;

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rd_q;
  logic [ADDR_W-1:0]     rd_addr;
  logic                  rd_en;

  logic [REQ_TYPE_W-1:0] type_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [POS_W-1:0]      pos_q;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      cap_q, cap_d;
  logic [CNT_W-1:0]      idx_q;
  logic [CNT_W-1:0]      idx_nxt;

  logic [63:0]           val_wide;
  logic [63:0]           rd_wide;

  logic [STATUS_W-1:0]   status_q;
  logic [VALUE_W-1:0]    data_q;
  logic [POS_W-1:0]      fpos_q;
  logic                  empty_q;
  logic                  full_q;
  logic [CNT_W-1:0]      cnt_res_q;

  assign val_wide = 64'(req_value_i);
  assign rd_wide  = 64'(rd_q);
  assign idx_nxt  = idx_q + CNT_W'(1);

  // effective capacity is clamped at write time
  always_comb begin
    cap_d = cfg_data_i;
    if (cfg_data_i == '0) begin
      cap_d = CNT_W'(1);
    end else if (32'(cfg_data_i) > DEPTH) begin
      cap_d = CNT_W'(DEPTH);
    end
  end

  always_comb begin
    rd_en   = cmd_i.start || cmd_i.scan_step;
    rd_addr = ADDR_W'(idx_nxt);
    if (cmd_i.start) begin
      case (req_type_i)
        REQ_POP, REQ_TOP: rd_addr = ADDR_W'(count_q - CNT_W'(1));
        REQ_FIND:         rd_addr = ADDR_W'(req_pos_i - POS_W'(1));
        default:          rd_addr = '0;
      endcase
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.push_en) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.pop_en) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  assign sts_o.req_type  = type_q;
  assign sts_o.cnt_zero  = (count_q == '0);
  assign sts_o.can_push  = (count_q < cap_q);
  assign sts_o.pos_ok    = (pos_q != '0) && (pos_q <= count_q);
  assign sts_o.match     = (rd_q == val_q);
  assign sts_o.scan_last = (idx_nxt >= count_q);

  // entry store: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.push_en) begin
      mem_q[ADDR_W'(count_q)] <= val_q;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      type_q <= req_type_i;
      val_q  <= val_wide[DATA_WIDTH-1:0];
      pos_q  <= req_pos_i;
    end
    if (cmd_i.start) begin
      idx_q <= '0;
    end else if (cmd_i.scan_step) begin
      idx_q <= idx_nxt;
    end
    if (cmd_i.res_load) begin
      status_q  <= cmd_i.res_status;
      data_q    <= cmd_i.res_data_en ? rd_wide[VALUE_W-1:0] : '0;
      fpos_q    <= cmd_i.res_fpos_en ? idx_nxt : '0;
      empty_q   <= (count_d == '0);
      full_q    <= (count_d >= cap_q);
      cnt_res_q <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= CNT_W'(CAP_RST);
    end else begin
      count_q <= count_d;
      if (cfg_we_i) begin
        cap_q <= cap_d;
      end
    end
  end

  assign status_o         = status_q;
  assign data_o           = data_q;
  assign found_position_o = fpos_q;
  assign empty_o          = empty_q;
  assign full_o           = full_q;
  assign count_o          = cnt_res_q;

`ifndef NO_ASSERTIONS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= DEPTH)
    else $error("entry count beyond store depth");

  a_push_pop_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push_en |-> !cmd_i.pop_en && !sts_o.cnt_zero == (count_q != '0) && count_q < cap_q)
    else $error("push issued without room");

  a_scan_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_step |-> idx_nxt < count_q)
    else $error("search stepped past the count");
`endif

endmodule

// ===== rtl/bounded_stack_with_search_core.sv =====
// Bounded LIFO stack with search.
// Channels: req_i takes one request (push, pop, top peek, find by position,
// search by value); rsp_o returns exactly one result per request with status,
// data, found position, and the empty/full flags and count after the request.
// cfg_i writes the capacity register; it is always ready and must only be
// written while no request is outstanding. Zero acts as 1, above DEPTH as DEPTH.
// Push, pop, top, find and unused codes read the entry store as the request
// is accepted; the execute state then loads the result register. Search
// reads one stored entry per cycle through the single registered read port
// of the entry store, stepping until the first match, or up to the count
// when nothing matches (an empty stack gives not found directly). One request
// is in flight at a time; the next request transfer can coincide with the
// transfer of the previous result.
// Reset: count clears to zero and capacity returns to min(256, DEPTH); the
// entry store is not cleared and needs no clearing pass.
// Stall: a result waits in the output register while rsp_o.ready is low, and
// req_i.ready stays low until that result leaves.
module bounded_stack_with_search_core #(
  parameter int unsigned DEPTH      = 256,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bss_req_if.sink    req_i,
  bss_cfg_if.sink    cfg_i,
  bss_rsp_if.source  rsp_o
);
  import bss_pkg::*;

  bss_cmd_t cmd;
  bss_sts_t sts;

  // capacity writes never stall
  assign cfg_i.ready = 1'b1;

  // sequencing: idle/execute states plus the result-valid flag
  bss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // entry store, count, capacity, request latch and result register
  bss_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .req_type_i       (req_i.req_type),
    .req_value_i      (req_i.value),
    .req_pos_i        (req_i.position),
    .cfg_we_i         (cfg_i.valid),
    .cfg_data_i       (cfg_i.data),
    .status_o         (rsp_o.status),
    .data_o           (rsp_o.data),
    .found_position_o (rsp_o.found_position),
    .empty_o          (rsp_o.empty_res),
    .full_o           (rsp_o.full_res),
    .count_o          (rsp_o.count)
  );

endmodule

// ===== sim/bounded_stack_with_search_core_tb.sv =====
module bounded_stack_with_search_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bss_pkg::*;

  localparam int unsigned STACK_DEPTH   = 256;
  localparam int unsigned QUIET_LIMIT   = 2000;  // cycles with no transfer at all
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned REPORT_MAX    = 10;
  localparam logic [CNT_W-1:0] CAP_AT_RESET = 9'd256;

  // request codes that the block must ignore
  localparam logic [REQ_TYPE_W-1:0] REQ_SPARE_FIRST = 3'd5;
  localparam logic [REQ_TYPE_W-1:0] REQ_SPARE_LAST  = 3'd7;

  // what one entry of the stimulus queue asks the driver to do
  typedef enum logic [1:0] {
    OP_REQ,    // one request transfer
    OP_CFG,    // capacity write, only once everything sent has come back
    OP_DRAIN   // hold off until every pending result has come back
  } op_kind_e;

  typedef struct {
    op_kind_e              kind;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [VALUE_W-1:0]    value;
    logic [POS_W-1:0]      position;
    logic [CNT_W-1:0]      capacity;
    bit                    calm;      // no idling on either side
  } stack_op_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  data;
    logic [POS_W-1:0]    found_position;
    logic                empty_res;
    logic                full_res;
    logic [CNT_W-1:0]    count;
  } stack_result_t;

  logic clk_i;
  logic rst_ni;

  bss_req_if req_if ();
  bss_cfg_if cfg_if ();
  bss_rsp_if rsp_if ();

  bounded_stack_with_search_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .cfg_i  (cfg_if),
    .rsp_o  (rsp_if)
  );

  // stimulus waiting to go out, and results owed by the block, oldest first
  stack_op_t     stack_ops_q[$];
  stack_result_t stack_results_q[$];

  // shadow copy of the stack and its capacity register
  logic [VALUE_W-1:0] shadow_mem [STACK_DEPTH];
  int unsigned        shadow_cnt;
  logic [CNT_W-1:0]   shadow_cap;

  logic [VALUE_W-1:0] value_pool [8];  // repeated values so searches hit
  bit                 gen_calm;
  bit                 quiet_mode;      // set by the driver, read by the monitor
  int unsigned        n_fail;
  int unsigned        quiet_cycles;

  always #1 clk_i = ~clk_i;

  // Works out the result of one request and updates the shadow stack.
  // Capacity zero behaves as one, anything above the depth as the depth.
  function automatic stack_result_t next_stack_result(
    input logic [REQ_TYPE_W-1:0] req_type,
    input logic [VALUE_W-1:0]    value,
    input logic [POS_W-1:0]      position
  );
    stack_result_t res;
    int unsigned   lim;
    res = '0;
    res.status = ST_OK;
    lim = (shadow_cap == '0) ? 1 : ((shadow_cap > STACK_DEPTH) ? STACK_DEPTH : shadow_cap);
    case (req_type)
      REQ_PUSH: begin
        // count may sit above a lowered capacity; push just overflows then
        if (shadow_cnt >= lim) begin
          res.status = ST_OVERFLOW;
        end else begin
          shadow_mem[shadow_cnt] = value;
          shadow_cnt++;
        end
      end
      REQ_POP: begin
        if (shadow_cnt == 0) begin
          res.status = ST_UNDERFLOW;
        end else begin
          shadow_cnt--;
          res.data = shadow_mem[shadow_cnt];
        end
      end
      REQ_TOP: begin
        if (shadow_cnt == 0) res.status = ST_UNDERFLOW;
        else res.data = shadow_mem[shadow_cnt-1];
      end
      REQ_FIND: begin
        // positions are 1-based from the bottom, 1..count only
        if (position == '0 || position > shadow_cnt) res.status = ST_BAD_POS;
        else res.data = shadow_mem[position-1];
      end
      REQ_SEARCH: begin
        res.status = ST_NOT_FOUND;
        for (int unsigned i = 0; i < shadow_cnt; i++) begin
          if (shadow_mem[i] == value) begin
            res.status = ST_OK;
            res.found_position = POS_W'(i + 1);
            break;
          end
        end
      end
      default: ;  // spare codes change nothing
    endcase
    res.empty_res = (shadow_cnt == 0);
    res.full_res  = (shadow_cnt >= lim);
    res.count     = CNT_W'(shadow_cnt);
    return res;
  endfunction

  function automatic void note_fail(input string msg);
    n_fail++;
    if (n_fail <= REPORT_MAX) $display("mismatch %0d at %0t: %s", n_fail, $realtime, msg);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    if ($urandom_range(0, 9) < 7) return value_pool[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  function automatic void add_req(input logic [REQ_TYPE_W-1:0] req_type,
                                  input logic [VALUE_W-1:0] value,
                                  input logic [POS_W-1:0] position);
    stack_op_t op;
    op = '{kind: OP_REQ, req_type: req_type, value: value, position: position,
           capacity: '0, calm: gen_calm};
    stack_ops_q.push_back(op);
  endfunction

  function automatic void add_cfg(input logic [CNT_W-1:0] capacity);
    stack_op_t op;
    op = '{kind: OP_CFG, req_type: REQ_PUSH, value: '0, position: '0,
           capacity: capacity, calm: gen_calm};
    stack_ops_q.push_back(op);
  endfunction

  function automatic void add_drain();
    stack_op_t op;
    op = '{kind: OP_DRAIN, req_type: REQ_PUSH, value: '0, position: '0,
           capacity: '0, calm: gen_calm};
    stack_ops_q.push_back(op);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver. Request and capacity write channels come from one queue; a held
  // valid stays up until its transfer. Counting both transfers here keeps the
  // idle check free of any ordering against the monitor.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : request_driver
    stack_op_t   cur;
    int unsigned gap_left;
    int unsigned n_sent;
    int unsigned n_back;
    logic        req_fire;
    logic        cfg_fire;
    logic        req_v_nxt;
    logic        cfg_v_nxt;
    if (!rst_ni) begin
      req_if.valid    <= 1'b0;
      req_if.req_type <= REQ_PUSH;
      req_if.value    <= '0;
      req_if.position <= '0;
      cfg_if.valid    <= 1'b0;
      cfg_if.data     <= '0;
      gap_left = 0;
      n_sent   = 0;
      n_back   = 0;
    end else begin
      req_fire = req_if.valid && req_if.ready;
      cfg_fire = cfg_if.valid && cfg_if.ready;
      if (req_fire) n_sent++;
      if (rsp_if.valid && rsp_if.ready) n_back++;
      if (req_fire || cfg_fire) void'(stack_ops_q.pop_front());
      req_v_nxt = req_if.valid && !req_fire;
      cfg_v_nxt = cfg_if.valid && !cfg_fire;
      if (!req_v_nxt && !cfg_v_nxt && stack_ops_q.size() != 0) begin
        cur = stack_ops_q[0];
        quiet_mode = cur.calm;
        if (gap_left != 0) begin
          gap_left--;
        end else if (cur.kind == OP_REQ && !cur.calm && $urandom_range(0, 9) == 0) begin
          // this cycle opens an idle gap before the request goes out
          gap_left = $urandom_range(0, 7);
        end else begin
          case (cur.kind)
            OP_REQ: begin
              req_v_nxt = 1'b1;
              req_if.req_type <= cur.req_type;
              req_if.value    <= cur.value;
              req_if.position <= cur.position;
            end
            OP_CFG: begin
              // capacity changes only with nothing in flight
              if (n_sent == n_back) begin
                cfg_v_nxt = 1'b1;
                cfg_if.data <= cur.capacity;
              end
            end
            default: begin
              if (n_sent == n_back) void'(stack_ops_q.pop_front());
            end
          endcase
        end
      end
      req_if.valid <= req_v_nxt;
      cfg_if.valid <= cfg_v_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Checks a result transfer against the oldest prediction first,
  // then folds in a capacity write and a request transfer of the same edge.
  // Also throttles rsp ready in random bursts.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    stack_result_t want;
    int unsigned   stall_left;
    logic          ready_nxt;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall_left = 0;
      shadow_cnt = 0;
      shadow_cap = CAP_AT_RESET;
      stack_results_q.delete();
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (stack_results_q.size() == 0) begin
          note_fail($sformatf("unexpected result st=%0d data=%h fpos=%0d cnt=%0d",
                              rsp_if.status, rsp_if.data, rsp_if.found_position,
                              rsp_if.count));
        end else begin
          want = stack_results_q.pop_front();
          if (want.status !== rsp_if.status || want.data !== rsp_if.data ||
              want.found_position !== rsp_if.found_position ||
              want.empty_res !== rsp_if.empty_res || want.full_res !== rsp_if.full_res ||
              want.count !== rsp_if.count) begin
            note_fail($sformatf(
              "exp st=%0d data=%h fpos=%0d e=%b f=%b cnt=%0d, got st=%0d data=%h fpos=%0d e=%b f=%b cnt=%0d",
              want.status, want.data, want.found_position, want.empty_res,
              want.full_res, want.count, rsp_if.status, rsp_if.data,
              rsp_if.found_position, rsp_if.empty_res, rsp_if.full_res, rsp_if.count));
          end
        end
      end
      if (cfg_if.valid && cfg_if.ready) shadow_cap = cfg_if.data;
      if (req_if.valid && req_if.ready) begin
        stack_results_q.push_back(next_stack_result(req_if.req_type, req_if.value,
                                                    req_if.position));
      end
      if (stall_left != 0) begin
        stall_left--;
        ready_nxt = 1'b0;
      end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 7);
        ready_nxt = 1'b0;
      end else begin
        ready_nxt = 1'b1;
      end
      rsp_if.ready <= ready_nxt;
    end
  end

  // watchdog: a long search walks at most the depth, so this is ample
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [CNT_W-1:0]      phase_caps [8];
    logic [REQ_TYPE_W-1:0] op;
    logic [POS_W-1:0]      pos;
    int unsigned           w;
    clk_i  = 1'b0;
    rst_ni = 1'b0;
    req_if.valid    = 1'b0;
    req_if.req_type = REQ_PUSH;
    req_if.value    = '0;
    req_if.position = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.data     = '0;
    rsp_if.ready    = 1'b0;
    n_fail       = 0;
    quiet_cycles = 0;
    quiet_mode   = 1'b0;
    gen_calm     = 1'b0;

    value_pool[0] = '0;
    value_pool[1] = '1;
    for (int i = 2; i < 8; i++) value_pool[i] = $urandom();

    // Directed: empty-stack errors, value extremes, overflow at a small
    // capacity, find bounds, search hit and miss, spare codes, then a
    // capacity lowered under the count, and popping past empty.
    add_cfg(9'd3);
    add_req(REQ_POP, '0, '0);
    add_req(REQ_TOP, '0, '0);
    add_req(REQ_FIND, '0, '0);
    add_req(REQ_SEARCH, '0, '0);
    add_req(REQ_PUSH, '0, '0);
    add_req(REQ_PUSH, '1, '0);
    add_req(REQ_PUSH, 32'h5a5a_a5a5, '0);
    add_req(REQ_PUSH, 32'h0000_0001, '0);
    add_req(REQ_TOP, '0, '0);
    add_req(REQ_FIND, '0, 9'd1);
    add_req(REQ_FIND, '0, 9'd3);
    add_req(REQ_FIND, '0, 9'd4);
    add_req(REQ_FIND, '0, '0);
    add_req(REQ_FIND, '0, '1);
    add_req(REQ_SEARCH, '1, '0);
    add_req(REQ_SEARCH, 32'h0000_1234, '0);
    for (int c = REQ_SPARE_FIRST; c <= REQ_SPARE_LAST; c++) begin
      add_req(REQ_TYPE_W'(c), '1, '1);
    end
    add_cfg(9'd2);
    add_req(REQ_PUSH, 32'hdead_beef, '0);
    repeat (4) add_req(REQ_POP, '0, '0);

    // Random phases over a spread of capacities, zero and out-of-range ones too
    phase_caps = '{9'd1, 9'd2, 9'd5, 9'd0, 9'd16, 9'd300, 9'd511, 9'd8};
    foreach (phase_caps[p]) begin
      add_cfg(phase_caps[p]);
      for (int n = 0; n < 28; n++) begin
        if (n == 14 && p % 2 == 0) add_drain();
        w = $urandom_range(0, 99);
        if (w < 40)      op = REQ_PUSH;
        else if (w < 62) op = REQ_POP;
        else if (w < 70) op = REQ_TOP;
        else if (w < 82) op = REQ_FIND;
        else if (w < 96) op = REQ_SEARCH;
        else             op = REQ_TYPE_W'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
        w = $urandom_range(0, 19);
        if (w < 12)      pos = POS_W'($urandom_range(1, 8));
        else if (w < 15) pos = '0;
        else if (w < 18) pos = POS_W'($urandom_range(9, 20));
        else             pos = POS_W'($urandom_range(0, 511));
        add_req(op, pick_value(), pos);
      end
    end

    // Last part, no idling: fill to the full depth, probe the top end,
    // then lower the capacity under a full stack and raise it past the depth.
    gen_calm = 1'b1;
    add_cfg(9'd256);
    repeat (30) add_req(REQ_POP, '0, '0);
    repeat (STACK_DEPTH + 1) add_req(REQ_PUSH, pick_value(), '0);
    add_req(REQ_FIND, '0, 9'd256);
    add_req(REQ_FIND, '0, 9'd257);
    add_req(REQ_FIND, '0, 9'd1);
    add_req(REQ_TOP, '0, '0);
    add_req(REQ_SEARCH, value_pool[0], '0);
    add_req(REQ_SEARCH, value_pool[7], '0);
    add_req(REQ_SEARCH, $urandom(), '0);
    add_cfg(9'd100);
    add_req(REQ_PUSH, pick_value(), '0);
    add_req(REQ_FIND, '0, 9'd256);
    add_req(REQ_POP, '0, '0);
    add_cfg(9'd511);
    add_req(REQ_PUSH, pick_value(), '0);
    add_req(REQ_PUSH, pick_value(), '0);
    add_req(REQ_POP, '0, '0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sample mid-cycle so the queues have settled
    do @(negedge clk_i);
    while (stack_ops_q.size() != 0 || req_if.valid || cfg_if.valid ||
           stack_results_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    if (n_fail == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
